// ===== rtl/vt52_text_output_encoder_top_macros.svh =====
// Assertion macros shared by the VT52 output encoder RTL.
`ifndef VT52_TEXT_OUTPUT_ENCODER_TOP_MACROS_SVH
`define VT52_TEXT_OUTPUT_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VT52_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VT52_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vt52_pkg.sv =====
// Types, codes, constants and microcode ROM of the VT52 output encoder.
package vt52_pkg;

    // Byte source selected by one microcode step.
    typedef enum logic [3:0] {
        SRC_ESC   = 4'd0,
        SRC_SPACE = 4'd1,
        SRC_BS    = 4'd2,
        SRC_LF    = 4'd3,
        SRC_Y     = 4'd4,
        SRC_M     = 4'd5,
        SRC_L     = 4'd6,
        SRC_P     = 4'd7,
        SRC_Q     = 4'd8,
        SRC_K     = 4'd9,
        SRC_OPA   = 4'd10,
        SRC_OPB   = 4'd11
    } src_t;

    typedef struct packed {
        src_t src;
        logic loop;   // repeat this step while the count is above one
        logic stop;   // final step of the program
    } uword_t;

    typedef enum logic [1:0] {
        OP_PUTC   = 2'd0,
        OP_GOTO   = 2'd1,
        OP_WINDOW = 2'd2,
        OP_EOL    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_SCREEN_ROWS   = 2'd0,
        CFG_TOP_TEXT_ROW  = 2'd1,
        CFG_UPPER_ROWS    = 2'd2,
        CFG_SCREEN_ENABLE = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        WIN_LOWER = 2'd0,
        WIN_UPPER = 2'd1,
        WIN_FULL  = 2'd2,
        WIN_NONE  = 2'd3
    } win_t;

    localparam int PC_W  = 5;
    localparam int CNT_W = 4;
    localparam int MAX_BURST = 12;

    // Program entry points in the microcode ROM.
    localparam logic [PC_W-1:0] PC_INV_OFF = 5'd0;
    localparam logic [PC_W-1:0] PC_INV_ON  = 5'd2;
    localparam logic [PC_W-1:0] PC_SCROLL  = 5'd4;
    localparam logic [PC_W-1:0] PC_LF      = 5'd16;
    localparam logic [PC_W-1:0] PC_BS      = 5'd17;
    localparam logic [PC_W-1:0] PC_TAB     = 5'd20;
    localparam logic [PC_W-1:0] PC_CHAR    = 5'd21;
    localparam logic [PC_W-1:0] PC_GOTO    = 5'd22;
    localparam logic [PC_W-1:0] PC_EOL     = 5'd26;

    // Put-char control codes.
    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_INV_OFF = 8'd1;
    localparam logic [7:0] CH_INV_ON  = 8'd2;
    localparam logic [7:0] CH_NOP_A   = 8'd3;
    localparam logic [7:0] CH_NOP_B   = 8'd4;
    localparam logic [7:0] CH_NOP_C   = 8'd5;
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_LF      = 8'd10;

    // Terminal bytes.
    localparam logic [7:0] BYTE_ESC   = 8'd27;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_Y     = 8'h59;
    localparam logic [7:0] BYTE_M     = 8'h4D;
    localparam logic [7:0] BYTE_L     = 8'h4C;
    localparam logic [7:0] BYTE_P     = 8'h70;
    localparam logic [7:0] BYTE_Q     = 8'h71;
    localparam logic [7:0] BYTE_K     = 8'h4B;

    localparam logic [5:0] ROW_MAX = 6'd63;
    localparam logic [7:0] COL_MAX = 8'd255;

    // Reset values.
    localparam logic [6:0] RST_SCREEN_ROWS  = 7'd25;
    localparam logic [5:0] RST_TOP_TEXT_ROW = 6'd1;
    localparam logic [5:0] RST_UPPER_ROWS   = 6'd0;
    localparam logic [5:0] RST_CUR_ROW      = 6'd24;

    function automatic uword_t uw(src_t s, logic l, logic st);
        uword_t w;
        w.src  = s;
        w.loop = l;
        w.stop = st;
        return w;
    endfunction

    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:    w = uw(SRC_ESC,   1'b0, 1'b0);
            5'd1:    w = uw(SRC_Q,     1'b0, 1'b1);
            5'd2:    w = uw(SRC_ESC,   1'b0, 1'b0);
            5'd3:    w = uw(SRC_P,     1'b0, 1'b1);
            5'd4:    w = uw(SRC_ESC,   1'b0, 1'b0);
            5'd5:    w = uw(SRC_Y,     1'b0, 1'b0);
            5'd6:    w = uw(SRC_OPA,   1'b0, 1'b0);
            5'd7:    w = uw(SRC_SPACE, 1'b0, 1'b0);
            5'd8:    w = uw(SRC_ESC,   1'b0, 1'b0);
            5'd9:    w = uw(SRC_M,     1'b0, 1'b0);
            5'd10:   w = uw(SRC_ESC,   1'b0, 1'b0);
            5'd11:   w = uw(SRC_Y,     1'b0, 1'b0);
            5'd12:   w = uw(SRC_OPB,   1'b0, 1'b0);
            5'd13:   w = uw(SRC_SPACE, 1'b0, 1'b0);
            5'd14:   w = uw(SRC_ESC,   1'b0, 1'b0);
            5'd15:   w = uw(SRC_L,     1'b0, 1'b1);
            5'd16:   w = uw(SRC_LF,    1'b0, 1'b1);
            5'd17:   w = uw(SRC_BS,    1'b0, 1'b0);
            5'd18:   w = uw(SRC_SPACE, 1'b0, 1'b0);
            5'd19:   w = uw(SRC_BS,    1'b0, 1'b1);
            5'd20:   w = uw(SRC_SPACE, 1'b1, 1'b1);
            5'd21:   w = uw(SRC_OPA,   1'b0, 1'b1);
            5'd22:   w = uw(SRC_ESC,   1'b0, 1'b0);
            5'd23:   w = uw(SRC_Y,     1'b0, 1'b0);
            5'd24:   w = uw(SRC_OPA,   1'b0, 1'b0);
            5'd25:   w = uw(SRC_OPB,   1'b0, 1'b1);
            5'd26:   w = uw(SRC_ESC,   1'b0, 1'b0);
            5'd27:   w = uw(SRC_K,     1'b0, 1'b1);
            default: w = uw(SRC_ESC,   1'b0, 1'b1);
        endcase
        return w;
    endfunction

    // Clamp a 7-bit row value to 0..63.
    function automatic logic [5:0] clamp_row(logic [6:0] v);
        return v[6] ? ROW_MAX : v[5:0];
    endfunction

endpackage

// ===== rtl/vt52_if.sv =====
// Request channels of the VT52 output encoder: command in, byte out, register write.
interface vt52_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [6:0] target_col;
    logic [5:0] target_row;
    logic [1:0] window_sel;

    modport source (output valid, opcode, char_code, target_col, target_row, window_sel,
                    input ready);
    modport sink (input valid, opcode, char_code, target_col, target_row, window_sel,
                  output ready);
endinterface

interface vt52_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    logic [7:0] col_now;
    logic [5:0] row_now;

    modport source (output valid, out_byte, last_byte, col_now, row_now, input ready);
    modport sink (input valid, out_byte, last_byte, col_now, row_now, output ready);
endinterface

interface vt52_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/vt52_text_output_encoder_top.sv =====
// VT52 output encoder: command decode, cursor state and microcoded byte sequencer.
//
// Usage:
//   cmd  (sink)   : one text-output request (put char, goto, select window, erase to EOL).
//   bytes (source): VT52 bytes, one per transfer, last_byte marks the end of a command;
//                   col_now / row_now carry the cursor after that command.
//   cfg  (sink)   : register writes, always ready, index 0..3 as screen_rows,
//                   top_text_row, upper_window_rows, screen_enable.
// A command is taken on a handshake; cursor, region and reverse flag update at that edge.
// Its bytes follow from the microcode ROM starting the next cycle, one per cycle
// while the receiver is ready. A command emits up to 12 bytes (a scrolling newline).
// The step counter and the tab repeat count set the byte count: one ROM step per byte.
// cmd ready is low while a sequence is in flight; a stalled receiver holds the
// current byte and the step counter.
// Reset (rst_n low, asynchronous) loads the register defaults, puts the cursor at
// column 0 of row 24, the region at rows 1..24, and clears reverse video.
module vt52_text_output_encoder_top #(
    parameter int TAB_STOP = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    vt52_in_if.sink    in_ch,
    vt52_out_if.source out_ch,
    vt52_cfg_if.sink   cfg_ch
);

    localparam int CNT_W = vt52_pkg::CNT_W;
    localparam int PC_W  = vt52_pkg::PC_W;
    localparam int LUT_N = 256;

    // Spaces a tab emits from each column, capped at the burst limit.
    function automatic logic [LUT_N*CNT_W-1:0] build_tab_lut();
        logic [LUT_N*CNT_W-1:0] lut;
        int n;
        lut = '0;
        for (int i = 0; i < LUT_N; i++)
        begin
            n = TAB_STOP - (i % TAB_STOP);
            if (n > vt52_pkg::MAX_BURST)
            begin
                n = vt52_pkg::MAX_BURST;
            end
            lut[i*CNT_W +: CNT_W] = CNT_W'(n);
        end
        return lut;
    endfunction

    localparam logic [LUT_N*CNT_W-1:0] TAB_LUT = build_tab_lut();

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } st_t;

    st_t                         state_reg, state_next;
    logic [PC_W-1:0]             pc_reg, pc_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [7:0]                  opa_reg, opa_next;
    logic [7:0]                  opb_reg, opb_next;

    logic [6:0] screen_rows_reg;
    logic [5:0] top_text_row_reg;
    logic [5:0] upper_rows_reg;
    logic       screen_enable_reg;

    logic [7:0] cur_col_reg, cur_col_next;
    logic [5:0] cur_row_reg, cur_row_next;
    logic [5:0] region_top_reg, region_top_next;
    logic [5:0] region_bottom_reg, region_bottom_next;
    logic       inverse_reg, inverse_next;

    vt52_pkg::uword_t word;
    logic             cmd_take;
    logic             byte_take;
    logic             repeat_step;
    logic             final_step;
    logic [CNT_W-1:0] tab_n;
    logic [8:0]       col_sum;
    logic [7:0]       col_add;
    logic [6:0]       rows_m1;
    logic [5:0]       last_row;
    logic [6:0]       top_up;
    logic [5:0]       upper_bottom;

    assign cmd_take  = in_ch.valid && in_ch.ready;
    assign byte_take = out_ch.valid && out_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_rows_reg   <= vt52_pkg::RST_SCREEN_ROWS;
            top_text_row_reg  <= vt52_pkg::RST_TOP_TEXT_ROW;
            upper_rows_reg    <= vt52_pkg::RST_UPPER_ROWS;
            screen_enable_reg <= 1'b1;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (vt52_pkg::cfg_idx_t'(cfg_ch.index))
                vt52_pkg::CFG_SCREEN_ROWS:   screen_rows_reg   <= cfg_ch.data;
                vt52_pkg::CFG_TOP_TEXT_ROW:  top_text_row_reg  <= cfg_ch.data[5:0];
                vt52_pkg::CFG_UPPER_ROWS:    upper_rows_reg    <= cfg_ch.data[5:0];
                vt52_pkg::CFG_SCREEN_ENABLE: screen_enable_reg <= cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    // Region bounds for window select.
    assign rows_m1      = screen_rows_reg - 7'd1;
    assign last_row     = (screen_rows_reg == 7'd0) ? 6'd0 : vt52_pkg::clamp_row(rows_m1);
    assign top_up       = {1'b0, top_text_row_reg} + {1'b0, upper_rows_reg};
    assign upper_bottom = (top_up == 7'd0) ? 6'd0 : vt52_pkg::clamp_row(top_up - 7'd1);

    assign tab_n   = TAB_LUT[{cur_col_reg, 2'b00} +: CNT_W];
    assign col_add = (in_ch.char_code == vt52_pkg::CH_TAB) ? 8'(tab_n) : 8'd1;
    assign col_sum = {1'b0, cur_col_reg} + {1'b0, col_add};

    // Sequencer step decode.
    assign word        = vt52_pkg::ucode(pc_reg);
    assign repeat_step = word.loop && (cnt_reg != CNT_W'(1));
    assign final_step  = word.stop && !repeat_step;

    always_comb
    begin
        state_next         = state_reg;
        pc_next            = pc_reg;
        cnt_next           = cnt_reg;
        opa_next           = opa_reg;
        opb_next           = opb_reg;
        cur_col_next       = cur_col_reg;
        cur_row_next       = cur_row_reg;
        region_top_next    = region_top_reg;
        region_bottom_next = region_bottom_reg;
        inverse_next       = inverse_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    unique case (vt52_pkg::op_t'(in_ch.opcode))
                        vt52_pkg::OP_PUTC:
                        begin
                            case (in_ch.char_code) inside
                                vt52_pkg::CH_INV_OFF:
                                begin
                                    if (inverse_reg)
                                    begin
                                        state_next   = ST_RUN;
                                        pc_next      = vt52_pkg::PC_INV_OFF;
                                        inverse_next = 1'b0;
                                    end
                                end
                                vt52_pkg::CH_INV_ON:
                                begin
                                    state_next   = ST_RUN;
                                    pc_next      = vt52_pkg::PC_INV_ON;
                                    inverse_next = 1'b1;
                                end
                                vt52_pkg::CH_NOP_A, vt52_pkg::CH_NOP_B, vt52_pkg::CH_NOP_C: ;
                                vt52_pkg::CH_LF:
                                begin
                                    if (screen_enable_reg)
                                    begin
                                        state_next   = ST_RUN;
                                        cur_col_next = 8'd0;
                                        if (cur_row_reg == region_bottom_reg)
                                        begin
                                            // scroll: delete region top line, open bottom line
                                            pc_next  = vt52_pkg::PC_SCROLL;
                                            opa_next = {2'b00, region_top_reg}
                                                       + vt52_pkg::BYTE_SPACE;
                                            opb_next = {2'b00, region_bottom_reg}
                                                       + vt52_pkg::BYTE_SPACE;
                                        end
                                        else
                                        begin
                                            pc_next = vt52_pkg::PC_LF;
                                            if (cur_row_reg != vt52_pkg::ROW_MAX)
                                            begin
                                                cur_row_next = cur_row_reg + 6'd1;
                                            end
                                        end
                                    end
                                end
                                vt52_pkg::CH_BS:
                                begin
                                    if (screen_enable_reg && (cur_col_reg != 8'd0))
                                    begin
                                        state_next   = ST_RUN;
                                        pc_next      = vt52_pkg::PC_BS;
                                        cur_col_next = cur_col_reg - 8'd1;
                                    end
                                end
                                default:
                                begin
                                    // tab and printable share the saturating column add
                                    if (screen_enable_reg)
                                    begin
                                        state_next   = ST_RUN;
                                        cur_col_next = col_sum[8] ? vt52_pkg::COL_MAX
                                                                  : col_sum[7:0];
                                        if (in_ch.char_code == vt52_pkg::CH_TAB)
                                        begin
                                            pc_next  = vt52_pkg::PC_TAB;
                                            cnt_next = tab_n;
                                        end
                                        else
                                        begin
                                            pc_next  = vt52_pkg::PC_CHAR;
                                            opa_next = (in_ch.char_code == vt52_pkg::CH_NUL)
                                                       ? vt52_pkg::BYTE_SPACE
                                                       : in_ch.char_code;
                                        end
                                    end
                                end
                            endcase
                        end
                        vt52_pkg::OP_GOTO:
                        begin
                            state_next   = ST_RUN;
                            pc_next      = vt52_pkg::PC_GOTO;
                            opa_next     = {2'b00, in_ch.target_row} + vt52_pkg::BYTE_SPACE;
                            opb_next     = {1'b0, in_ch.target_col} + vt52_pkg::BYTE_SPACE;
                            cur_col_next = {1'b0, in_ch.target_col};
                            cur_row_next = in_ch.target_row;
                        end
                        vt52_pkg::OP_WINDOW:
                        begin
                            unique case (vt52_pkg::win_t'(in_ch.window_sel))
                                vt52_pkg::WIN_LOWER:
                                begin
                                    region_top_next    = vt52_pkg::clamp_row(top_up);
                                    region_bottom_next = last_row;
                                end
                                vt52_pkg::WIN_UPPER:
                                begin
                                    region_top_next    = top_text_row_reg;
                                    region_bottom_next = upper_bottom;
                                end
                                vt52_pkg::WIN_FULL:
                                begin
                                    region_top_next    = top_text_row_reg;
                                    region_bottom_next = last_row;
                                end
                                vt52_pkg::WIN_NONE: ;
                                default: ;
                            endcase
                        end
                        vt52_pkg::OP_EOL:
                        begin
                            state_next = ST_RUN;
                            pc_next    = vt52_pkg::PC_EOL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                if (byte_take)
                begin
                    if (final_step)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (repeat_step)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            pc_reg            <= '0;
            cnt_reg           <= '0;
            cur_col_reg       <= 8'd0;
            cur_row_reg       <= vt52_pkg::RST_CUR_ROW;
            region_top_reg    <= vt52_pkg::RST_TOP_TEXT_ROW;
            region_bottom_reg <= vt52_pkg::RST_CUR_ROW;
            inverse_reg       <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            pc_reg            <= pc_next;
            cnt_reg           <= cnt_next;
            cur_col_reg       <= cur_col_next;
            cur_row_reg       <= cur_row_next;
            region_top_reg    <= region_top_next;
            region_bottom_reg <= region_bottom_next;
            inverse_reg       <= inverse_next;
        end
    end

    // Operand bytes need no reset.
    always_ff @(posedge clk)
    begin
        opa_reg <= opa_next;
        opb_reg <= opb_next;
    end

    // Byte source select.
    always_comb
    begin
        unique case (word.src)
            vt52_pkg::SRC_ESC:   out_ch.out_byte = vt52_pkg::BYTE_ESC;
            vt52_pkg::SRC_SPACE: out_ch.out_byte = vt52_pkg::BYTE_SPACE;
            vt52_pkg::SRC_BS:    out_ch.out_byte = vt52_pkg::BYTE_BS;
            vt52_pkg::SRC_LF:    out_ch.out_byte = vt52_pkg::BYTE_LF;
            vt52_pkg::SRC_Y:     out_ch.out_byte = vt52_pkg::BYTE_Y;
            vt52_pkg::SRC_M:     out_ch.out_byte = vt52_pkg::BYTE_M;
            vt52_pkg::SRC_L:     out_ch.out_byte = vt52_pkg::BYTE_L;
            vt52_pkg::SRC_P:     out_ch.out_byte = vt52_pkg::BYTE_P;
            vt52_pkg::SRC_Q:     out_ch.out_byte = vt52_pkg::BYTE_Q;
            vt52_pkg::SRC_K:     out_ch.out_byte = vt52_pkg::BYTE_K;
            vt52_pkg::SRC_OPA:   out_ch.out_byte = opa_reg;
            vt52_pkg::SRC_OPB:   out_ch.out_byte = opb_reg;
            default:             out_ch.out_byte = vt52_pkg::BYTE_ESC;
        endcase
    end

    assign out_ch.valid     = (state_reg == ST_RUN);
    assign out_ch.last_byte = final_step;
    assign out_ch.col_now   = cur_col_reg;
    assign out_ch.row_now   = cur_row_reg;

`include "vt52_text_output_encoder_top_macros.svh"

    `VT52_ASSERT_NOW(a_no_take_while_sending, out_ch.valid, !in_ch.ready,
        "request taken mid-sequence")
    `VT52_ASSERT_NOW(a_loop_count_live, (state_reg == ST_RUN) && word.loop,
        cnt_reg != '0, "tab count empty")
    `VT52_ASSERT_NEXT(a_idle_after_last, byte_take && out_ch.last_byte, in_ch.ready,
        "no idle after last byte")
    `VT52_ASSERT_NEXT(a_hold_on_stall, out_ch.valid && !out_ch.ready,
        $stable(pc_reg) && $stable(cnt_reg), "step moved on stall")

endmodule
